// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/gri_pkg.sv -----
package gri_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_X_OFFSET    = 2'd0;
  localparam logic [1:0] CFG_INTERVAL    = 2'd1;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

  // Input item kinds.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Kind of answer a query takes.
  typedef enum logic [1:0] {
    SEL_FIRST,
    SEL_LAST,
    SEL_BLEND
  } sel_t;

endpackage

// ----- rtl/gri_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
module gri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gri_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Divides a (QW)-bit value num by a DW-bit den. Carries a tag along.
module gri_divider #(
  parameter int QW = 48,
  parameter int DW = 31,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  logic          vld_r [QW+1];
  logic [QW-1:0] num_r [QW+1];
  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [TW-1:0] tag_r [QW+1];

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
  end

  // Each stage shifts in one numerator bit and tries one subtraction.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [QW-1:0] num_nxt;
    logic [DW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[s], num_r[s][QW-1]};
      diff    = trial - {1'b0, den_r[s]};
      take    = (trial >= {1'b0, den_r[s]});
      num_nxt = {num_r[s][QW-2:0], take};
      rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s+1] <= num_nxt;
        rem_r[s+1] <= rem_nxt;
        den_r[s+1] <= den_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign out_quo = num_r[QW];
  assign out_tag = tag_r[QW];

endmodule

// ----- rtl/gri_blend.sv -----
// Two-stage weighted blend of two signed values, rounding half up.
module gri_blend #(
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  logic [FB-1:0] f,
  input  logic          avg,
  output logic [31:0]   y
);

  logic [31:0]   ua;
  logic [31:0]   ub;
  logic [FB:0]   wa;
  logic [FB:0]   wb;
  logic [32+FB:0] pa_r;
  logic [32+FB:0] pb_r;
  logic [32+FB+1:0] sum;

  // An average is a blend with weight one half on both sides.
  always_comb begin
    ua = a ^ 32'h8000_0000;
    ub = b ^ 32'h8000_0000;
    wb = avg ? (FB+1)'(1) << (FB-1) : {1'b0, f};
    wa = ((FB+1)'(1) << FB) - wb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= (33+FB)'(ua) * (33+FB)'(wa);
      pb_r <= (33+FB)'(ub) * (33+FB)'(wb);
    end
  end

  assign sum = (34+FB)'(pa_r) + (34+FB)'(pb_r) + ((34+FB)'(1) << (FB-1));

  always_ff @(posedge clk) begin
    if (en) begin
      y <= sum[FB+31:FB] ^ 32'h8000_0000;
    end
  end

endmodule

// ----- rtl/grid_range_interpolator_unit.sv -----
// Range grid interpolator. Takes one item per cycle on a valid/stall channel:
// load items (mode 0) write a table point, query items (mode 1) give one
// result each, through stages whose number does not depend on MAX_POINTS:
// one subtract stage, the bit-per-stage divider (32+FRAC_BITS+1 stages),
// one table read stage and two blend stages. Load items travel the same
// pipeline and write the table where queries read it, so every item sees
// the table as left by the items before it. Throughput is one item per
// cycle; a stall on the result side freezes the whole pipeline. Table
// entries must be written before they are read. Configuration must be
// written only while idle; the block itself does not enforce this.
`include "assert_macros.svh"
module grid_range_interpolator_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_query_x,
  input  logic [9:0]  in_point_index,
  input  logic [31:0] in_lower_value,
  input  logic [31:0] in_upper_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_range_low,
  output logic [31:0] out_range_high
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int QW = 33 + FRAC_BITS;
  localparam int CW = AW + 1;
  localparam int TW = AW + 68;

  logic [31:0] x_offset_r;
  logic [30:0] interval_r;
  logic [10:0] count_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= '0;
      interval_r <= 31'd65536;
      count_r    <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gri_pkg::CFG_X_OFFSET:    x_offset_r <= cfg_data;
        gri_pkg::CFG_INTERVAL:    interval_r <= cfg_data[30:0];
        gri_pkg::CFG_POINT_COUNT: count_r    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Effective point count, interval and last index.
  logic [CW-1:0] n_eff;
  logic [CW-1:0] last;
  logic [30:0]   step;
  always_comb begin
    if (count_r == 11'd0) begin
      n_eff = CW'(1);
    end else if (32'(count_r) > 32'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(count_r);
    end
    last = n_eff - CW'(1);
    step = (interval_r == 31'd0) ? 31'd1 : interval_r;
  end

  // The whole pipeline advances unless the result is stalled.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic acc;
  assign acc = in_valid && en;

  // Stage 1: offset position, plus the load data that rides along.
  logic          s1_vld_r;
  logic          s1_qry_r;
  logic          s1_wr_r;
  logic [AW-1:0] s1_idx_r;
  logic [31:0]   s1_lo_r;
  logic [31:0]   s1_hi_r;
  logic [32:0]   s1_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= acc;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r   <= {in_query_x[31], in_query_x} - {x_offset_r[31], x_offset_r};
      s1_qry_r <= (in_mode == gri_pkg::MODE_QUERY);
      s1_wr_r  <= (in_mode == gri_pkg::MODE_LOAD) &&
                  (32'(in_point_index) < 32'(MAX_POINTS));
      s1_idx_r <= AW'(in_point_index);
      s1_lo_r  <= in_lower_value;
      s1_hi_r  <= in_upper_value;
    end
  end

  // Divide d << FRAC_BITS by the step; tag carries the clamp case.
  logic [1:0] s1_sel;
  logic       s1_nonpos;
  always_comb begin
    s1_nonpos = s1_d_r[32] || (s1_d_r == 33'd0);
    s1_sel = s1_nonpos ? 2'(gri_pkg::SEL_FIRST) : 2'(gri_pkg::SEL_BLEND);
  end

  logic          dv_vld;
  logic [QW-1:0] dv_quo;
  logic [TW-1:0] dv_tag;
  gri_divider #(.QW(QW), .DW(31), .TW(TW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(s1_vld_r),
    .in_num({1'b0, s1_d_r[31:0], {FRAC_BITS{1'b0}}}),
    .in_den(step),
    .in_tag({s1_qry_r, s1_wr_r, s1_idx_r, s1_lo_r, s1_hi_r, s1_sel}),
    .out_vld(dv_vld), .out_quo(dv_quo), .out_tag(dv_tag)
  );

  // Fields of the item leaving the divider.
  logic          dv_qry;
  logic          dv_wr;
  logic [AW-1:0] dv_idx;
  logic [31:0]   dv_lo;
  logic [31:0]   dv_hi;
  logic [1:0]    dv_sel;
  assign {dv_qry, dv_wr, dv_idx, dv_lo, dv_hi, dv_sel} = dv_tag;

  // Stage after divide: pick index and weight, issue table reads.
  logic [QW-FRAC_BITS-1:0] k_full;
  logic [FRAC_BITS-1:0]    f_val;
  logic [1:0]              sel;
  logic [AW-1:0]           ra0;
  logic [AW-1:0]           ra1;
  always_comb begin
    k_full = dv_quo[QW-1:FRAC_BITS];
    f_val  = dv_quo[FRAC_BITS-1:0];
    sel    = dv_sel;
    if (dv_sel == 2'(gri_pkg::SEL_BLEND) && k_full >= (QW-FRAC_BITS)'(last)) begin
      sel = 2'(gri_pkg::SEL_LAST);
    end
    ra0 = '0;
    ra1 = '0;
    if (sel == 2'(gri_pkg::SEL_LAST)) begin
      ra0 = last[AW-1:0];
      ra1 = last[AW-1:0];
    end else if (sel == 2'(gri_pkg::SEL_BLEND)) begin
      ra0 = k_full[AW-1:0];
      ra1 = k_full[AW-1:0] + AW'(1);
    end
  end

  // Loads write the table at the same stage where queries read it.
  logic lw_we;
  assign lw_we = en && dv_vld && dv_wr;

  logic [31:0] lo0, lo1, hi0, hi1;
  gri_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_lo0 (
    .clk(clk), .we(lw_we), .waddr(dv_idx), .wdata(dv_lo),
    .re(en), .raddr(ra0), .rdata(lo0));
  gri_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_lo1 (
    .clk(clk), .we(lw_we), .waddr(dv_idx), .wdata(dv_lo),
    .re(en), .raddr(ra1), .rdata(lo1));
  gri_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_hi0 (
    .clk(clk), .we(lw_we), .waddr(dv_idx), .wdata(dv_hi),
    .re(en), .raddr(ra0), .rdata(hi0));
  gri_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_hi1 (
    .clk(clk), .we(lw_we), .waddr(dv_idx), .wdata(dv_hi),
    .re(en), .raddr(ra1), .rdata(hi1));

  // Control travelling alongside the table read.
  logic                 rd_vld_r;
  logic                 rd_avg_r;
  logic [FRAC_BITS-1:0] rd_f_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (en) begin
      rd_vld_r <= dv_vld && dv_qry;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rd_avg_r <= (sel != 2'(gri_pkg::SEL_BLEND));
      rd_f_r   <= f_val;
    end
  end

  // For averages both reads hit the same point; blend low with high bound.
  logic [31:0] la, lb, ha, hb;
  always_comb begin
    if (rd_avg_r) begin
      la = lo0; lb = hi0; ha = lo0; hb = hi0;
    end else begin
      la = lo0; lb = lo1; ha = hi0; hb = hi1;
    end
  end

  gri_blend #(.FB(FRAC_BITS)) u_bl_lo (
    .clk(clk), .en(en), .a(la), .b(lb), .f(rd_f_r), .avg(rd_avg_r), .y(out_range_low));
  gri_blend #(.FB(FRAC_BITS)) u_bl_hi (
    .clk(clk), .en(en), .a(ha), .b(hb), .f(rd_f_r), .avg(rd_avg_r), .y(out_range_high));

  logic bl_vld_r;
  logic out_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      bl_vld_r  <= rd_vld_r;
      out_vld_r <= bl_vld_r;
    end
  end
  assign out_valid = out_vld_r;

  // A stalled result must hold its value; checked on the low bound.
  `ASSERT_NEXT(a_hold_low, clk, rst_n, out_valid && out_stall, $stable(out_range_low))
  // Input is refused only while a result is stalled.
  `ASSERT_IMPLIES(a_stall, clk, rst_n, in_stall, out_valid && out_stall)
  // Averages always read the same table point on both ports.
  `ASSERT_IMPLIES(a_avg_addr, clk, rst_n, dv_vld && dv_qry && sel != 2'(gri_pkg::SEL_BLEND), ra0 == ra1)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC = 16;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
  } range_t;

  // Directed stimulus row; expected range is typed in only where obvious.
  typedef struct {
    logic        mode;
    logic [31:0] x;
    logic [9:0]  idx;
    logic [31:0] lo;
    logic [31:0] hi;
    bit          typed;
    range_t      want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_mode;
  logic [31:0] in_query_x;
  logic [9:0] in_point_index;
  logic [31:0] in_lower_value;
  logic [31:0] in_upper_value;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_range_low;
  logic [31:0] out_range_high;

  // Shadow of the block's table and registers.
  logic [31:0] lower_tbl [TABLE_DEPTH];
  logic [31:0] upper_tbl [TABLE_DEPTH];
  logic [31:0] sh_offset;
  logic [30:0] sh_interval;
  logic [10:0] sh_count;

  range_t pending_ranges[$];
  int errors;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles;

  grid_range_interpolator_unit i_dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] to_biased(logic [31:0] v);
    return {32'd0, v ^ 32'h8000_0000};
  endfunction

  function automatic logic [31:0] average(logic [31:0] a, logic [31:0] b);
    logic [63:0] s;
    s = (to_biased(a) + to_biased(b) + 64'd1) >> 1;
    return s[31:0] ^ 32'h8000_0000;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [63:0] f);
    logic [63:0] one;
    logic [63:0] s;
    one = 64'd1 << FRAC;
    s = to_biased(a) * (one - f) + to_biased(b) * f + (one >> 1);
    s = s >> FRAC;
    return s[31:0] ^ 32'h8000_0000;
  endfunction

  function automatic int eff_count();
    if (sh_count == 0) return 1;
    if (sh_count > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(sh_count);
  endfunction

  function automatic logic [63:0] eff_interval();
    return (sh_interval == 0) ? 64'd1 : {33'd0, sh_interval};
  endfunction

  // Interpolated range at a query position.
  function automatic range_t interpolate(logic [31:0] qx);
    range_t r;
    longint d;
    logic [63:0] step;
    logic [63:0] last;
    logic [63:0] k;
    logic [63:0] f;
    step = eff_interval();
    last = 64'(eff_count() - 1);
    d = longint'($signed(qx)) - longint'($signed(sh_offset));
    if (d <= 0) begin
      r.low = average(lower_tbl[0], upper_tbl[0]);
      r.high = r.low;
    end else if (64'(d) >= last * step) begin
      r.low = average(lower_tbl[last], upper_tbl[last]);
      r.high = r.low;
    end else begin
      k = 64'(d) / step;
      f = ((64'(d) % step) << FRAC) / step;
      r.low = blend(lower_tbl[k], lower_tbl[k + 1], f);
      r.high = blend(upper_tbl[k], upper_tbl[k + 1], f);
    end
    return r;
  endfunction

  // Offer one item and wait until the block takes it; returns at a falling edge.
  task automatic send_item(logic mode, logic [31:0] x, logic [9:0] idx,
                           logic [31:0] lo, logic [31:0] hi, bit typed, range_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_query_x <= x;
    in_point_index <= idx;
    in_lower_value <= lo;
    in_upper_value <= hi;
    do @(posedge clk); while (in_stall);
    if (mode == gri_pkg::MODE_LOAD) begin
      lower_tbl[idx] = lo;
      upper_tbl[idx] = hi;
    end else begin
      pending_ranges.push_back(typed ? want : interpolate(x));
    end
    @(negedge clk);
  endtask

  task automatic send_load(logic [9:0] idx, logic [31:0] lo, logic [31:0] hi);
    send_item(gri_pkg::MODE_LOAD, $urandom, idx, lo, hi, 1'b0, '0);
  endtask

  task automatic send_query(logic [31:0] x);
    send_item(gri_pkg::MODE_QUERY, x, 10'($urandom), $urandom, $urandom, 1'b0, '0);
  endtask

  // Let the pipeline empty, including loads that cause no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gri_pkg::CFG_X_OFFSET: sh_offset = value;
      gri_pkg::CFG_INTERVAL: sh_interval = value[30:0];
      gri_pkg::CFG_POINT_COUNT: sh_count = value[10:0];
      default: ;
    endcase
  endtask

  // Query position: mostly inside the active grid, sometimes anywhere.
  function automatic logic [31:0] pick_query();
    longint pos;
    int n;
    n = eff_count();
    if ($urandom_range(99) < 20) return $urandom;
    pos = longint'($signed(sh_offset)) + longint'($urandom_range(n - 1)) * longint'(eff_interval())
        + longint'($urandom) % longint'(eff_interval());
    if ($urandom_range(99) < 5) pos = longint'($signed(sh_offset)) + $urandom_range(2) - 1;
    if (pos > 64'sh7fff_ffff || pos < -64'sh8000_0000) return $urandom;
    return pos[31:0];
  endfunction

  // Receiver stall, with one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    range_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, out_range_low, out_range_high);
        errors++;
      end else begin
        want = pending_ranges.pop_front();
        if (out_range_low !== want.low) begin
          $display("%0t: range_low expected %h actual %h", $time, want.low, out_range_low);
          errors++;
        end
        if (out_range_high !== want.high) begin
          $display("%0t: range_high expected %h actual %h", $time, want.high, out_range_high);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    logic [31:0] ph_offset [8];
    logic [31:0] ph_interval [8];
    logic [31:0] ph_count [8];
    row_t rw;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = gri_pkg::MODE_LOAD;
    in_query_x = '0;
    in_point_index = '0;
    in_lower_value = '0;
    in_upper_value = '0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    quiet_cycles = 0;
    sh_offset = '0;
    sh_interval = 31'd65536;
    sh_count = 11'd1;
    foreach (lower_tbl[i]) begin
      lower_tbl[i] = '0;
      upper_tbl[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on a three point grid at unit spacing.
    write_reg(gri_pkg::CFG_POINT_COUNT, 32'd3);
    rows = '{
      '{gri_pkg::MODE_LOAD, 0, 0, 32'd100, 32'd200, 0, '0},
      '{gri_pkg::MODE_LOAD, 0, 1, 32'h8000_0000, 32'h7fff_ffff, 0, '0},
      '{gri_pkg::MODE_LOAD, 0, 2, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0},
      '{gri_pkg::MODE_LOAD, 0, 1023, 32'd1, 32'd2, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'h8000_0000, 0, 0, 0, 1, '{32'd150, 32'd150}},
      '{gri_pkg::MODE_QUERY, 32'd0, 0, 0, 0, 1, '{32'd150, 32'd150}},
      '{gri_pkg::MODE_QUERY, 32'h7fff_ffff, 0, 0, 0, 1, '{32'h7fff_ffff, 32'h7fff_ffff}},
      '{gri_pkg::MODE_QUERY, 32'd131072, 0, 0, 0, 1, '{32'h7fff_ffff, 32'h7fff_ffff}},
      '{gri_pkg::MODE_QUERY, 32'd65536, 0, 0, 0, 1, '{32'h8000_0000, 32'h7fff_ffff}},
      '{gri_pkg::MODE_QUERY, 32'd32768, 0, 0, 0, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'd98304, 0, 0, 0, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'd1, 0, 0, 0, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'd131071, 0, 0, 0, 0, '0},
      '{gri_pkg::MODE_LOAD, 0, 0, 32'hffff_ffff, 32'd0, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'hffff_fffb, 0, 0, 0, 1, '{32'd0, 32'd0}},
      '{gri_pkg::MODE_LOAD, 0, 1, 32'h8000_0000, 32'h8000_0000, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'd65536, 0, 0, 0, 1, '{32'h8000_0000, 32'h8000_0000}},
      '{gri_pkg::MODE_QUERY, 32'd40000, 0, 0, 0, 0, '0},
      '{gri_pkg::MODE_QUERY, 32'd100000, 0, 0, 0, 0, '0}
    };
    foreach (rows[i]) begin
      rw = rows[i];
      send_item(rw.mode, rw.x, rw.idx, rw.lo, rw.hi, rw.typed, rw.want);
    end
    drain();

    // Fill the whole table so any later query reads written entries.
    for (int i = 0; i < TABLE_DEPTH; i++) send_load(10'(i), $urandom, $urandom);
    drain();

    // Register settings per phase, extremes and out-of-range values among them.
    ph_offset = '{32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd0,
                  32'hfff0_0000, $urandom, 32'd12345, 32'd0};
    ph_interval = '{32'd65536, 32'd1, 32'hffff_ffff, 32'd0,
                    32'd4096, $urandom_range(1, 1 << 20), 32'd3, 32'd7};
    ph_count = '{32'd16, 32'd1024, 32'd2, 32'd0,
                 32'd2047, $urandom_range(1, 1024), 32'd1000, 32'd1};
    write_reg(CFG_UNUSED, $urandom);
    for (int p = 0; p < 8; p++) begin
      write_reg(gri_pkg::CFG_X_OFFSET, ph_offset[p]);
      write_reg(gri_pkg::CFG_INTERVAL, ph_interval[p]);
      write_reg(gri_pkg::CFG_POINT_COUNT, ph_count[p]);
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 82; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 82; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(99) < 70) send_query(pick_query());
        else send_load(10'($urandom), $urandom, $urandom);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- grid_range_interpolator_unit.f -----
+incdir+rtl
rtl/gri_pkg.sv
rtl/gri_ram.sv
rtl/gri_divider.sv
rtl/gri_blend.sv
rtl/grid_range_interpolator_unit.sv
tb/testbench.sv
